@@ design/lgs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the life grid generation step
// Grid geometry, request codes, register map and the rule constants.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam int MAX_SIDE  = 64;
	localparam int MAX_CELLS = MAX_SIDE * MAX_SIDE;
	localparam int SIDE_W    = $clog2(MAX_SIDE);
	localparam int SIZE_W    = SIDE_W + 1;
	localparam int MEM_ROWS  = 2 * MAX_SIDE;
	localparam int MEM_AW    = SIDE_W + 1;
	localparam int PTR_W     = $clog2(MAX_SIDE + 2);
	localparam int CFG_W     = 7;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	typedef logic [1:0] req_t;
	localparam req_t REQ_WRITE   = 2'd0;
	localparam req_t REQ_READ    = 2'd1;
	localparam req_t REQ_ADVANCE = 2'd2;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef struct packed {
		logic [SIZE_W-1:0]   width;
		logic [SIZE_W-1:0]   height;
		logic [MAX_SIDE-1:0] col_mask;
	} grid_cfg_t;

	// clamp a register value to the usable range 1..MAX_SIDE
	function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > MAX_SIDE) begin
			r = SIZE_W'(MAX_SIDE);
		end else begin
			r = SIZE_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/lgs_cell_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_cell_mem: cell store, both banks
// One row of cells per word, bank in the top address bit. One write port,
// one read port, read data registered.
// ----------------------------------------------------------------------------
module lgs_cell_mem
	import lgs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [MEM_AW-1:0]   wr_addr,
	input  wire logic [MAX_SIDE-1:0] wr_data,
	input  wire logic                rd_en,
	input  wire logic [MEM_AW-1:0]   rd_addr,
	output logic      [MAX_SIDE-1:0] rd_data
);

	logic [MAX_SIDE-1:0] mem_q [MEM_ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/lgs_row_next.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_row_next: next generation of one row
// One lane per column; counts the Moore neighbours from three rows and
// applies the birth and survival rule.
// ----------------------------------------------------------------------------
module lgs_row_next
	import lgs_pkg::*;
(
	input  wire logic [MAX_SIDE-1:0] above,
	input  wire logic [MAX_SIDE-1:0] mid,
	input  wire logic [MAX_SIDE-1:0] below,
	input  wire logic [MAX_SIDE-1:0] col_mask,
	input  wire logic                row_ok,
	output logic      [MAX_SIDE-1:0] next_row
);

	logic [MAX_SIDE+1:0] ap, mp, bp;
	logic [3:0]          n;

	assign ap = {1'b0, above, 1'b0};
	assign mp = {1'b0, mid, 1'b0};
	assign bp = {1'b0, below, 1'b0};

	always_comb begin
		n = '0;
		for (int i = 0; i < MAX_SIDE; i++) begin
			n = 4'(ap[i]) + 4'(ap[i+1]) + 4'(ap[i+2])
			  + 4'(mp[i]) + 4'(mp[i+2])
			  + 4'(bp[i]) + 4'(bp[i+1]) + 4'(bp[i+2]);
			next_row[i] = row_ok && col_mask[i]
				&& ((n == BIRTH_COUNT) || (mid[i] && (n == SURVIVE_COUNT)));
		end
	end

endmodule
`default_nettype wire

@@ design/lgs_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_cfg: configuration registers
// APB access to grid width and height; clamped sizes and column mask out.
// ----------------------------------------------------------------------------
module lgs_cfg
	import lgs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output grid_cfg_t              grid_cfg
);

	logic [CFG_W-1:0] grid_width_q, grid_height_q;
	logic             wr_strobe;

	assign pready    = 1'b1;
	assign wr_strobe = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_W'(MAX_SIDE);
			grid_height_q <= CFG_W'(MAX_SIDE);
		end else if (wr_strobe) begin
			case (paddr[2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[CFG_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH:  prdata = APB_DW'(grid_width_q);
			REG_GRID_HEIGHT: prdata = APB_DW'(grid_height_q);
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		grid_cfg.width  = eff_size(grid_width_q);
		grid_cfg.height = eff_size(grid_height_q);
		for (int i = 0; i < MAX_SIDE; i++) begin
			grid_cfg.col_mask[i] = (i < int'(grid_cfg.width));
		end
	end

endmodule
`default_nettype wire

@@ design/life_grid_generation_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_generation_step: bounded B3/S23 grid, double buffered
// Top level: request sequencer around the row-wide cell store.
// ----------------------------------------------------------------------------
// The grid lives in one synchronous memory, one row of cells per word, with
// two banks; a bank bit selects the current one. After reset a clearing pass
// writes every row of both banks dead, one row a cycle, and no word is taken
// until it ends. Each word on the s side is one request: a cell write or
// read runs through accept, row read, and modify and write back; an advance
// runs through accept, the window steps and completion. In an advance the
// single read port of the store reads one row a cycle, the two rows above it
// are held in registers, and the row before is written to the other bank as
// the next generation; then the banks swap. Rows and columns outside the
// configured grid read as dead and are written dead.
// Every request yields one result word; a result waits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
module life_grid_generation_step
	import lgs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,   // cell_x[5:0], cell_y[11:6], write_alive[12], zero
	input  wire logic [1:0]        s_tuser,   // req_type[1:0]
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [7:0]        m_tdata,   // read_alive[0], generation_done[1], zero
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD    = 6'b000100,
		ST_MOD   = 6'b001000,
		ST_ADV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [MEM_AW-1:0]   clr_q;
	logic                bank_q;
	req_t                req_q;
	logic [SIDE_W-1:0]   x_q, y_q;
	logic                wv_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [MAX_SIDE-1:0] above_q, mid_q;
	logic                m_valid_q;
	logic                read_alive_q, gen_done_q;

	grid_cfg_t           grid_cfg;

	logic                mem_wr_en, mem_rd_en;
	logic [MEM_AW-1:0]   mem_wr_addr, mem_rd_addr;
	logic [MAX_SIDE-1:0] mem_wr_data, mem_rd_data;

	logic                in_range, out_free, accept, res_load;
	logic                below_ok, res_ok, res_valid;
	logic [MAX_SIDE-1:0] below_row, next_row, mod_row;
	logic [PTR_W-1:0]    res_row;

	lgs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.grid_cfg (grid_cfg)
	);

	lgs_cell_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, gen_done_q, read_alive_q};

	// load a result word once the output register is free
	assign res_load = out_free && ((state_q == ST_MOD) || (state_q == ST_DONE));

	// addressed cell inside the grid in use
	assign in_range = (SIZE_W'(x_q) < grid_cfg.width) && (SIZE_W'(y_q) < grid_cfg.height);

	// advance window: row ptr-1 arrives from the store, row ptr-2 is produced
	assign below_ok  = (ptr_q != '0) && ((int'(ptr_q) - 1) < int'(grid_cfg.height));
	assign below_row = mem_rd_data & grid_cfg.col_mask & {MAX_SIDE{below_ok}};
	assign res_row   = ptr_q - PTR_W'(2);
	assign res_valid = (int'(ptr_q) >= 2);
	assign res_ok    = res_valid && (int'(res_row) < int'(grid_cfg.height));

	lgs_row_next u_row_next (
		.above    (above_q),
		.mid      (mid_q),
		.below    (below_row),
		.col_mask (grid_cfg.col_mask),
		.row_ok   (res_ok),
		.next_row (next_row)
	);

	// single-cell update of the fetched row
	always_comb begin
		mod_row       = mem_rd_data;
		mod_row[x_q]  = wv_q;
	end

	// store port steering
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = clr_q;
		mem_wr_data = '0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = {bank_q, y_q};
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			ST_RD: begin
				mem_rd_en = 1'b1;
			end
			ST_MOD: begin
				mem_wr_en   = out_free && (req_q == REQ_WRITE) && in_range;
				mem_wr_addr = {bank_q, y_q};
				mem_wr_data = mod_row;
			end
			ST_ADV: begin
				mem_rd_en   = (int'(ptr_q) < MAX_SIDE);
				mem_rd_addr = {bank_q, ptr_q[SIDE_W-1:0]};
				mem_wr_en   = res_valid;
				mem_wr_addr = {!bank_q, res_row[SIDE_W-1:0]};
				mem_wr_data = next_row;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			bank_q    <= 1'b0;
			ptr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// hold a waiting word, drop it once taken, set it on a new result
			m_valid_q <= res_load || (m_valid_q && !m_tready);
			case (state_q)
				ST_CLEAR: begin
					// sweep both banks once
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == REQ_ADVANCE) begin
							ptr_q   <= '0;
							state_q <= ST_ADV;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ADV: begin
					ptr_q <= ptr_q + PTR_W'(1);
					if (int'(ptr_q) == MAX_SIDE + 1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// swap banks together with the completion word
					if (out_free) begin
						bank_q  <= !bank_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= s_tuser;
			x_q   <= s_tdata[5:0];
			y_q   <= s_tdata[11:6];
			wv_q  <= s_tdata[12];
		end
		if (state_q == ST_IDLE) begin
			above_q <= '0;
			mid_q   <= '0;
		end else if ((state_q == ST_ADV) && (ptr_q != '0)) begin
			// shift the row window down by one
			above_q <= mid_q;
			mid_q   <= below_row;
		end
		if ((state_q == ST_MOD) && out_free) begin
			read_alive_q <= (req_q == REQ_READ) && in_range && mem_rd_data[x_q];
			gen_done_q   <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			read_alive_q <= 1'b0;
			gen_done_q   <= 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ design/lgs_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_checker: port-level checks for the life grid generation step
// Result word encoding, one request in flight, output hold under stall, ready APB port.
// ----------------------------------------------------------------------------
module lgs_checker
	import lgs_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       pready
);

	// a result is a read value or a completion, never both, and the padding bits are zero
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[7:2] == '0))
		else $error("result word carries both kinds or padding bits");

	// one request at a time: no word taken on the cycle after a take
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous one in progress");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed or dropped");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port stalled");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (.*);
`default_nettype wire

@@ bench/life_grid_checker.sv @@
// ----------------------------------------------------------------------------
// life_grid_checker: grid predictor and result comparison
// Watches the request, result and register channels, keeps its own copy of
// the grid and sizes, and compares every result word with the prediction.
// ----------------------------------------------------------------------------
module life_grid_checker
	import lgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,   // cell_x[5:0], cell_y[11:6], write_alive[12], zero
	input  logic [1:0]        s_tuser,   // req_type[1:0]
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,   // read_alive[0], generation_done[1], zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	output int                mismatches,
	output int                answers_pending,
	output int                generations,
	output int                live_reads
);

	typedef struct packed {
		logic read_alive;
		logic generation_done;
	} grid_answer_t;

	bit [MAX_CELLS-1:0] life_cells;
	logic [CFG_W-1:0]   width_reg  = CFG_W'(MAX_SIDE);
	logic [CFG_W-1:0]   height_reg = CFG_W'(MAX_SIDE);
	grid_answer_t       answers_due [$];
	grid_answer_t       due, got;
	req_t               kind;
	logic               cfg_index;
	logic [CFG_W-1:0]   cfg_value;
	int                 cx, cy, side_w, side_h;

	initial begin
		mismatches      = 0;
		answers_pending = 0;
		generations     = 0;
		live_reads      = 0;
	end

	function automatic int usable_side(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > MAX_SIDE) begin
			return MAX_SIDE;
		end
		return int'(v);
	endfunction

	// cells beyond the configured edge read as dead, whatever is stored there
	function automatic bit live_at(input int x, input int y, input int w, input int h);
		if (x < 0 || y < 0 || x >= w || y >= h) begin
			return 1'b0;
		end
		return life_cells[y*MAX_SIDE + x];
	endfunction

	task automatic breed_next_generation();
		bit [MAX_CELLS-1:0] next_cells;
		int w, h, n;
		w = usable_side(width_reg);
		h = usable_side(height_reg);
		next_cells = '0;
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dx = -1; dx <= 1; dx++) begin
						if (dx != 0 || dy != 0) begin
							n += live_at(x + dx, y + dy, w, h);
						end
					end
				end
				if (life_cells[y*MAX_SIDE + x]) begin
					next_cells[y*MAX_SIDE + x] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
				end else begin
					next_cells[y*MAX_SIDE + x] = (n == BIRTH_COUNT);
				end
			end
		end
		life_cells = next_cells;
		generations++;
	endtask

	task automatic flag_mismatch(input string what);
		if (mismatches < 40) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_cells = '0;
			width_reg  = CFG_W'(MAX_SIDE);
			height_reg = CFG_W'(MAX_SIDE);
			answers_due.delete();
			answers_pending = 0;
		end else begin
			if (psel && penable && pready) begin
				cfg_index = paddr[APB_AW-1:2];
				cfg_value = (cfg_index == REG_GRID_HEIGHT) ? height_reg : width_reg;
				if (pwrite && cfg_index == REG_GRID_HEIGHT) begin
					height_reg = pwdata[CFG_W-1:0];
				end else if (pwrite) begin
					width_reg = pwdata[CFG_W-1:0];
				end else if (prdata[CFG_W-1:0] !== cfg_value) begin
					flag_mismatch($sformatf("register %0d reads %0d, holds %0d",
						cfg_index, prdata[CFG_W-1:0], cfg_value));
				end
			end
			// results first: a word leaving now belongs to an earlier request
			if (m_tvalid && m_tready) begin
				got = grid_answer_t'({m_tdata[0], m_tdata[1]});
				if (answers_due.size() == 0) begin
					flag_mismatch($sformatf("result word %b with nothing outstanding", m_tdata));
				end else begin
					due = answers_due.pop_front();
					if (got.read_alive !== due.read_alive) begin
						flag_mismatch($sformatf("read_alive %b, expected %b",
							got.read_alive, due.read_alive));
					end
					if (got.generation_done !== due.generation_done) begin
						flag_mismatch($sformatf("generation_done %b, expected %b",
							got.generation_done, due.generation_done));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				kind   = s_tuser;
				cx     = int'(s_tdata[5:0]);
				cy     = int'(s_tdata[11:6]);
				side_w = usable_side(width_reg);
				side_h = usable_side(height_reg);
				due    = '0;
				case (kind)
					REQ_WRITE: begin
						if (cx < side_w && cy < side_h) begin
							life_cells[cy*MAX_SIDE + cx] = s_tdata[12];
						end
					end
					REQ_READ: begin
						due.read_alive = live_at(cx, cy, side_w, side_h);
						live_reads += due.read_alive;
					end
					REQ_ADVANCE: begin
						breed_next_generation();
						due.generation_done = 1'b1;
					end
					default: begin
					end
				endcase
				answers_due.push_back(due);
			end
			answers_pending = answers_due.size();
		end
	end

endmodule

@@ bench/life_grid_generation_step_tb.sv @@
// ----------------------------------------------------------------------------
// life_grid_generation_step_tb: bench for the bounded life grid
// Drives cell writes, reads and generation steps over a run of grid sizes,
// with random gaps on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module life_grid_generation_step_tb;
	import lgs_pkg::*;

	// request code the block must swallow without effect
	localparam req_t REQ_UNUSED      = 2'd3;
	localparam int   WATCHDOG_LIMIT  = 2000;
	localparam int   DRAIN_CYCLES    = 100;
	localparam int   PHASES          = 7;
	localparam int   ITEMS_PER_PHASE = 17;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;   // cell_x[5:0], cell_y[11:6], write_alive[12], zero
	logic [1:0]        s_tuser;   // req_type[1:0]
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;   // read_alive[0], generation_done[1], zero
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int mismatches, answers_pending, generations, live_reads;
	int requests, ready_wait, stall_cycles;
	int side_w, side_h, span_x, span_y, ox, oy, roll;
	bit no_idle;

	// grid sizes per phase: extremes, out-of-range values and small grids
	logic [CFG_W-1:0] width_plan  [PHASES] = '{7'd8, 7'd0, 7'd127, 7'd3, 7'd64, 7'd100, 7'd2};
	logic [CFG_W-1:0] height_plan [PHASES] = '{7'd8, 7'd127, 7'd0, 7'd64, 7'd3, 7'd6, 7'd2};

	life_grid_generation_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	life_grid_checker grid_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.answers_pending (answers_pending),
		.generations     (generations),
		.live_reads      (live_reads)
	);

	always #5 clk = ~clk;

	// Hand one request word to the block: idle a random number of cycles,
	// present the word at a falling edge and hold it until it is taken.
	// Valid stays high on return so back-to-back words need no gap.
	task automatic send_request(input req_t kind, input int x, input int y, input bit alive);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = kind;
		s_tdata  = {3'b000, alive, 6'(y), 6'(x)};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		requests++;
		@(negedge clk);
	endtask

	// setup cycle, then access cycle until pready; the checker sees both kinds
	task automatic access_register(input logic index, input bit write_it,
			input logic [CFG_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = write_it;
		paddr   = APB_AW'({index, 2'b00});
		pwdata  = APB_DW'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Result side: stall a random number of cycles before each word,
	// then hold ready until a word has been taken.
	always begin
		ready_wait = no_idle ? 0 : $urandom_range(0, 4);
		if (ready_wait != 0) begin
			m_tready = 1'b0;
			repeat (ready_wait) @(negedge clk);
		end
		m_tready = 1'b1;
		do @(posedge clk); while (!m_tvalid);
		@(negedge clk);
	end

	// Watchdog: give up once no word has moved on either stream for too long.
	// The clearing pass after reset and the longest step fit well inside.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("timeout after %0d idle cycles, %0d results outstanding",
			WATCHDOG_LIMIT, answers_pending);
		$display("life_grid_generation_step verification failed");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_WRITE;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		no_idle  = 1'b0;
		requests = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part on the full 64 x 64 grid left by reset.
		// Cleared store, then the far corner at the top of both coordinates.
		send_request(REQ_READ, 0, 0, 1'b0);
		send_request(REQ_WRITE, 63, 63, 1'b1);
		send_request(REQ_READ, 63, 63, 1'b0);
		// overwrite a live cell with dead
		send_request(REQ_WRITE, 0, 0, 1'b1);
		send_request(REQ_WRITE, 0, 0, 1'b0);
		send_request(REQ_READ, 0, 0, 1'b0);
		// blinker against the top edge: the row above counts as dead
		send_request(REQ_WRITE, 10, 0, 1'b1);
		send_request(REQ_WRITE, 11, 0, 1'b1);
		send_request(REQ_WRITE, 12, 0, 1'b1);
		// three cells of a block: the fourth is born
		send_request(REQ_WRITE, 5, 5, 1'b1);
		send_request(REQ_WRITE, 6, 5, 1'b1);
		send_request(REQ_WRITE, 5, 6, 1'b1);
		// unused code with every field bit set: must change nothing
		send_request(REQ_UNUSED, 63, 63, 1'b1);
		send_request(REQ_ADVANCE, 0, 0, 1'b0);
		// the lone corner cell has no neighbours and must die
		send_request(REQ_READ, 63, 63, 1'b0);
		send_request(REQ_READ, 11, 1, 1'b0);
		send_request(REQ_READ, 11, 0, 1'b0);
		send_request(REQ_READ, 10, 0, 1'b0);
		send_request(REQ_READ, 6, 6, 1'b0);
		send_request(REQ_ADVANCE, 63, 63, 1'b1);
		send_request(REQ_READ, 10, 0, 1'b0);
		send_request(REQ_READ, 12, 0, 1'b0);
		s_tvalid = 1'b0;
		wait (answers_pending == 0);
		@(negedge clk);

		// Random part: one grid setting per phase, changed only while idle.
		for (int p = 0; p < PHASES; p++) begin
			access_register(REG_GRID_WIDTH, 1'b1, width_plan[p]);
			access_register(REG_GRID_HEIGHT, 1'b1, height_plan[p]);
			access_register(REG_GRID_WIDTH, 1'b0, '0);
			access_register(REG_GRID_HEIGHT, 1'b0, '0);
			side_w = (width_plan[p] == 0) ? 1 :
				(int'(width_plan[p]) > MAX_SIDE ? MAX_SIDE : int'(width_plan[p]));
			side_h = (height_plan[p] == 0) ? 1 :
				(int'(height_plan[p]) > MAX_SIDE ? MAX_SIDE : int'(height_plan[p]));
			// every third phase runs both streams flat out
			no_idle = (p % 3 == 1);
			// keep writes and reads in a small window so patterns interact
			span_x = (side_w < 6) ? side_w : 6;
			span_y = (side_h < 6) ? side_h : 6;
			ox = $urandom_range(0, side_w - span_x);
			oy = $urandom_range(0, side_h - span_y);
			repeat (ITEMS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					send_request(REQ_WRITE, ox + $urandom_range(0, span_x - 1),
						oy + $urandom_range(0, span_y - 1), $urandom_range(0, 3) != 0);
				end else if (roll < 68) begin
					send_request(REQ_READ, ox + $urandom_range(0, span_x - 1),
						oy + $urandom_range(0, span_y - 1), $urandom_range(0, 1));
				end else if (roll < 83) begin
					send_request(REQ_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 1));
				end else if (roll < 95) begin
					// anywhere in the address space, often off the grid
					send_request(req_t'($urandom_range(0, 1)), $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom_range(0, 1));
				end else begin
					send_request(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 1));
				end
			end
			s_tvalid = 1'b0;
			wait (answers_pending == 0);
			@(negedge clk);
		end

		// drain: let any stray word turn up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d request words over %0d grid settings", requests, PHASES + 1);
		$display("%0d generations stepped, %0d reads of a live cell", generations, live_reads);
		if (mismatches == 0 && answers_pending == 0) begin
			$display("life_grid_generation_step verification clean");
		end else begin
			$display("life_grid_generation_step verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/lgs_pkg.sv
design/lgs_cell_mem.sv
design/lgs_row_next.sv
design/lgs_cfg.sv
design/life_grid_generation_step.sv
design/lgs_checker.sv
bench/life_grid_checker.sv
bench/life_grid_generation_step_tb.sv
